// File: rtl/sha1md_pkg.sv
// ----------------------------------------------------------------------------
// sha1md_pkg
// shared types, constants and round functions of the sha-1 digest unit
// ----------------------------------------------------------------------------
package sha1md_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned RoundW  = 7;
  localparam int unsigned NumVars = 5;
  localparam int unsigned Rounds  = 80;

  localparam logic [WordW-1:0] IV [NumVars] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  localparam logic [WordW-1:0] K0 = 32'h5a827999;
  localparam logic [WordW-1:0] K1 = 32'h6ed9eba1;
  localparam logic [WordW-1:0] K2 = 32'h8f1bbcdc;
  localparam logic [WordW-1:0] K3 = 32'hca62c1d6;

  localparam logic [WordW-1:0] MarkWord = 32'h80000000;
  localparam logic [7:0]       PadByte  = 8'h80;

  localparam logic [SlotW-1:0]  SlotLast    = 4'd15;
  localparam logic [SlotW-1:0]  SlotBeforeL = 4'd13;
  localparam logic [SlotW-1:0]  SlotLenHi   = 4'd14;
  localparam logic [RoundW-1:0] RoundLast   = 7'(Rounds - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MARK,
    ST_ZERO,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    WSEL_DATA,
    WSEL_MARK,
    WSEL_ZERO,
    WSEL_LEN_HI,
    WSEL_LEN_LO
  } wsel_t;

  typedef struct packed {
    logic  push;
    wsel_t wsel;
    logic  count;
    logic  load;
    logic  round;
    logic  fold;
    logic  pop;
    logic  restart;
  } cmd_t;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic             last_full;
    logic             round_last;
    logic             out_last;
  } stat_t;

  // final word: keep valid bytes, append the 0x80 marker when room remains
  function automatic logic [WordW-1:0] pad_word(input logic [WordW-1:0] data,
                                                input logic [2:0] cnt);
    logic [WordW-1:0] w;
    begin
      case (cnt)
        3'd0:    w = {PadByte, 24'h0};
        3'd1:    w = {data[31:24], PadByte, 16'h0};
        3'd2:    w = {data[31:16], PadByte, 8'h0};
        3'd3:    w = {data[31:8], PadByte};
        default: w = data;
      endcase
      return w;
    end
  endfunction

  function automatic logic [WordW-1:0] round_f(input logic [RoundW-1:0] t,
                                               input logic [WordW-1:0] b,
                                               input logic [WordW-1:0] c,
                                               input logic [WordW-1:0] d);
    logic [WordW-1:0] f;
    begin
      if (t < 7'd20) begin
        f = d ^ (b & (c ^ d));
      end else if (t < 7'd40) begin
        f = b ^ c ^ d;
      end else if (t < 7'd60) begin
        f = (b & c) | (d & (b | c));
      end else begin
        f = b ^ c ^ d;
      end
      return f;
    end
  endfunction

  function automatic logic [WordW-1:0] round_k(input logic [RoundW-1:0] t);
    logic [WordW-1:0] k;
    begin
      if (t < 7'd20) begin
        k = K0;
      end else if (t < 7'd40) begin
        k = K1;
      end else if (t < 7'd60) begin
        k = K2;
      end else begin
        k = K3;
      end
      return k;
    end
  endfunction

endpackage

// File: rtl/sha1md_datapath.sv
// ----------------------------------------------------------------------------
// sha1md_datapath
// schedule window, round variables, chain value, byte count and digest mux
// ----------------------------------------------------------------------------
module sha1md_datapath
  import sha1md_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output stat_t            stat,
  input  logic [WordW-1:0] data_word,
  input  logic [2:0]       byte_count,
  input  logic             is_last,
  output logic [WordW-1:0] digest_word,
  output logic             digest_end
);

  logic [WordW-1:0]  chain [NumVars];
  logic [WordW-1:0]  vars  [NumVars];
  logic [WordW-1:0]  sched [16];
  logic [63:0]       message_bytes;
  logic [SlotW-1:0]  word_slot;
  logic [RoundW-1:0] round_number;
  logic [2:0]        out_idx;

  logic [WordW-1:0] push_word;
  logic [WordW-1:0] w_mix;
  logic [WordW-1:0] w_new;
  logic [WordW-1:0] tmp;
  logic [63:0]      bit_len;
  logic [3:0]       add_bytes;
  logic [2:0]       sat_cnt;

  assign sat_cnt   = byte_count[2] ? 3'd4 : byte_count;
  assign add_bytes = is_last ? {1'b0, sat_cnt} : 4'd4;
  assign bit_len   = {message_bytes[60:0], 3'b000};

  always_comb begin
    case (cmd.wsel)
      WSEL_DATA:   push_word = is_last ? pad_word(data_word, sat_cnt) : data_word;
      WSEL_MARK:   push_word = MarkWord;
      WSEL_LEN_HI: push_word = bit_len[63:32];
      WSEL_LEN_LO: push_word = bit_len[31:0];
      default:     push_word = '0;
    endcase
  end

  // next schedule word, window holds w[t] .. w[t+15]
  assign w_mix = sched[0] ^ sched[2] ^ sched[8] ^ sched[13];
  assign w_new = {w_mix[30:0], w_mix[31]};
  assign tmp   = {vars[0][26:0], vars[0][31:27]}
               + round_f(round_number, vars[1], vars[2], vars[3])
               + vars[4] + round_k(round_number) + sched[0];

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      for (int i = 0; i < 15; i++) begin
        sched[i] <= sched[i+1];
      end
      sched[15] <= push_word;
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        sched[i] <= sched[i+1];
      end
      sched[15] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < NumVars; i++) begin
        vars[i] <= chain[i];
      end
    end else if (cmd.round) begin
      vars[0] <= tmp;
      vars[1] <= vars[0];
      vars[2] <= {vars[1][1:0], vars[1][31:2]};
      vars[3] <= vars[2];
      vars[4] <= vars[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      for (int i = 0; i < NumVars; i++) begin
        chain[i] <= IV[i];
      end
    end else if (cmd.fold) begin
      for (int i = 0; i < NumVars; i++) begin
        chain[i] <= chain[i] + vars[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      message_bytes <= '0;
    end else if (cmd.count) begin
      message_bytes <= message_bytes + {60'd0, add_bytes};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_slot <= '0;
    end else if (cmd.push) begin
      word_slot <= word_slot + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      round_number <= '0;
    end else if (cmd.round) begin
      round_number <= (round_number == RoundLast) ? '0 : round_number + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      out_idx <= '0;
    end else if (cmd.pop) begin
      out_idx <= out_idx + 3'd1;
    end
  end

  always_comb begin
    case (out_idx)
      3'd0:    digest_word = chain[0];
      3'd1:    digest_word = chain[1];
      3'd2:    digest_word = chain[2];
      3'd3:    digest_word = chain[3];
      default: digest_word = chain[4];
    endcase
  end

  assign digest_end      = (out_idx == 3'd4);
  assign stat.slot       = word_slot;
  assign stat.last_full  = byte_count[2];
  assign stat.round_last = (round_number == RoundLast);
  assign stat.out_last   = digest_end;

endmodule

// File: rtl/sha1md_ctrl.sv
// ----------------------------------------------------------------------------
// sha1md_ctrl
// sequencer for word intake, padding, compression and digest output
// ----------------------------------------------------------------------------
module sha1md_ctrl
  import sha1md_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_last,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;
  state_t ret;
  state_t ret_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret   <= ST_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_comb begin
    state_t succ;
    logic   pushing;
    succ       = ST_IDLE;
    pushing    = 1'b0;
    state_next = state;
    ret_next   = ret;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          pushing = 1'b1;
          if (!in_last) begin
            succ = ST_IDLE;
          end else if (stat.last_full) begin
            succ = ST_MARK;
          end else begin
            succ = (stat.slot == SlotBeforeL) ? ST_LEN_HI : ST_ZERO;
          end
        end
      end
      ST_MARK, ST_ZERO: begin
        pushing = 1'b1;
        succ    = (stat.slot == SlotBeforeL) ? ST_LEN_HI : ST_ZERO;
      end
      ST_LEN_HI: begin
        pushing = 1'b1;
        succ    = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        pushing = 1'b1;
        succ    = ST_OUT;
      end
      ST_ROUND: begin
        if (stat.round_last) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        state_next = ret;
      end
      ST_OUT: begin
        if (out_ready && stat.out_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (pushing) begin
      if (stat.slot == SlotLast) begin
        state_next = ST_ROUND;
        ret_next   = succ;
      end else begin
        state_next = succ;
      end
    end
  end

  always_comb begin
    cmd      = '0;
    cmd.wsel = WSEL_ZERO;
    case (state)
      ST_IDLE: begin
        cmd.push  = in_valid;
        cmd.count = in_valid;
        cmd.wsel  = WSEL_DATA;
      end
      ST_MARK: begin
        cmd.push = 1'b1;
        cmd.wsel = WSEL_MARK;
      end
      ST_ZERO: begin
        cmd.push = 1'b1;
      end
      ST_LEN_HI: begin
        cmd.push = 1'b1;
        cmd.wsel = WSEL_LEN_HI;
      end
      ST_LEN_LO: begin
        cmd.push = 1'b1;
        cmd.wsel = WSEL_LEN_LO;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
      end
      ST_OUT: begin
        cmd.pop     = out_ready;
        cmd.restart = out_ready && stat.out_last;
      end
      default: begin
        cmd.push = 1'b0;
      end
    endcase
    cmd.load = cmd.push && (stat.slot == SlotLast);
  end

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output open together");

  a_round_to_fold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && stat.round_last) |=> (state == ST_FOLD))
    else $error("compression did not end in fold");

  a_len_slot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LEN_HI) |-> (stat.slot == SlotLenHi))
    else $error("length pushed at wrong slot");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && stat.out_last) |=> (in_ready && stat.slot == '0))
    else $error("digest end not followed by clean idle");
`endif

endmodule

// File: rtl/sha1_message_digest_unit.sv
// ----------------------------------------------------------------------------
// sha1_message_digest_unit
// sha-1 digest over a byte message delivered in 32-bit words
// ----------------------------------------------------------------------------
// Words arrive first byte in bits 31..24; byte_count in tuser only matters on
// the tlast word (values above four count as four). A word is taken whenever
// the unit is idle; every sixteenth word starts a compression, one round per
// cycle, followed by a fold into the chain value, and no word is taken until
// the fold is done. After the last word the padding words go in one per cycle
// outside compressions, with one or two compressions in all, then the digest
// words A to E are offered in five items, tlast on E. No new input is taken
// until E has been delivered.
module sha1_message_digest_unit
  import sha1md_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // data_word
  input  logic [2:0]  s_axis_tuser,   // byte_count
  input  logic        s_axis_tlast,   // is_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // digest_word
  output logic        m_axis_tlast    // digest_end
);

  cmd_t  cmd;
  stat_t stat;

  sha1md_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_last   (s_axis_tlast),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sha1md_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .data_word   (s_axis_tdata),
    .byte_count  (s_axis_tuser),
    .is_last     (s_axis_tlast),
    .digest_word (m_axis_tdata),
    .digest_end  (m_axis_tlast)
  );

endmodule
